FILE: hdl/rba_pkg.sv
// shared types and constants of the ring buffer allocator
`default_nettype none
package rba_pkg;
  localparam int KIND_W   = 2;
  localparam int SIZE_W   = 21;
  localparam int ADDR_W   = 32;
  localparam int STATUS_W = 3;

  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_OWNS  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_WAIT      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

  localparam logic REG_BUFFER_SIZE  = 1'b0;
  localparam logic REG_BASE_ADDRESS = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CLEAN,
    S_CHECK,
    S_SEARCH
  } state_t;

  typedef struct packed {
    logic shift;
    logic load;
    logic mark;
  } cell_ctrl_t;
endpackage
`default_nettype wire

FILE: hdl/ring_buffer_allocator.sv
// top level of the ring buffer allocator: sequencer, config registers, cell row
//
// channel   direction  handshake                      payload
// command   in         start & !busy                  kind, size, address
// result    out        done, one cycle, no stall      status, granted_address, owned
// config    in         psel & penable & pwrite        paddr, pwdata (prdata on read)
//
// a free or query passes S_SEARCH before done; an allocate passes S_CLEAN,
// which drops freed head entries one at a time, then S_CHECK; too large and
// unknown kinds answer from S_IDLE. busy is high while a beat is in work,
// and a new beat may be accepted in the cycle its predecessor shows done.
// rst is synchronous and empties the queue. the result side cannot stall.
`default_nettype none
module ring_buffer_allocator import rba_pkg::*; #(
  parameter int MAX_ENTRIES = 16,
  parameter int OFFSET_BITS = 20
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [KIND_W-1:0]   kind,
  input  wire logic [SIZE_W-1:0]   size,
  input  wire logic [ADDR_W-1:0]   address,
  output logic                     done,
  output logic [STATUS_W-1:0]      status,
  output logic [ADDR_W-1:0]        granted_address,
  output logic                     owned,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  // lim holds up to 2^OFFSET_BITS or a full buffer_size value
  localparam int LW = (OFFSET_BITS + 1 > SIZE_W) ? OFFSET_BITS + 1 : SIZE_W;
  localparam int W  = LW + 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int IW = $clog2(MAX_ENTRIES);
  localparam logic [LW-1:0] RANGE_MAX = LW'(1) << OFFSET_BITS;

  // configuration registers
  logic [SIZE_W-1:0] buffer_size;
  logic [ADDR_W-1:0] base_address;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size  <= SIZE_W'(1048576);
      base_address <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_BUFFER_SIZE) begin
        buffer_size <= pwdata[SIZE_W-1:0];
      end else begin
        base_address <= pwdata;
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_BUFFER_SIZE) begin
      prdata = 32'(buffer_size);
    end else begin
      prdata = base_address;
    end
  end

  // sequencer state
  state_t             state, state_next;
  logic [KIND_W-1:0]  kind_q, kind_q_next;
  logic [SIZE_W-1:0]  size_q, size_q_next;
  logic [ADDR_W-1:0]  addr_q, addr_q_next;
  logic [OFFSET_BITS-1:0] start_q, start_q_next;
  logic [CW-1:0]      count, count_next;
  logic [LW-1:0]      next_offset, next_offset_next;
  logic               done_next, owned_next;
  logic [STATUS_W-1:0] status_next;
  logic [ADDR_W-1:0]  granted_next;

  // cell row
  cell_ctrl_t             ctrl [MAX_ENTRIES];
  logic [OFFSET_BITS-1:0] offs [MAX_ENTRIES];
  logic                   frd  [MAX_ENTRIES];
  logic                   mt   [MAX_ENTRIES];

  genvar g;
  generate
    for (g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      // the head sits in cell 0; each cell takes its upper neighbor on a drop
      if (g == MAX_ENTRIES - 1) begin : g_last
        rba_cell #(.OFFSET_BITS(OFFSET_BITS)) u_cell (
          .clk, .rst, .ctrl(ctrl[g]), .load_offset(start_q),
          .up_offset('0), .up_freed(1'b0),
          .base(base_address), .addr(addr_q),
          .offset(offs[g]), .freed(frd[g]), .match(mt[g])
        );
      end else begin : g_mid
        rba_cell #(.OFFSET_BITS(OFFSET_BITS)) u_cell (
          .clk, .rst, .ctrl(ctrl[g]), .load_offset(start_q),
          .up_offset(offs[g+1]), .up_freed(frd[g+1]),
          .base(base_address), .addr(addr_q),
          .offset(offs[g]), .freed(frd[g]), .match(mt[g])
        );
      end
    end
  endgenerate

  // effective size and allocation bounds
  logic [LW-1:0] lim;
  logic [W-1:0]  acc_end, chk_end;
  logic          hit, room;
  logic [IW-1:0] hit_idx;

  assign lim     = (LW'(buffer_size) > RANGE_MAX) ? RANGE_MAX : LW'(buffer_size);
  assign acc_end = W'(next_offset) + W'(size);
  assign chk_end = W'(start_q) + W'(size_q);
  assign room    = !((count != '0) && (W'(offs[0]) >= W'(start_q)) &&
                     (W'(offs[0]) < chk_end));

  // newest live match: highest queue position wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (mt[i] && (CW'(i) < count)) begin
        hit     = 1'b1;
        hit_idx = IW'(i);
      end
    end
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      next_offset <= '0;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      count       <= count_next;
      next_offset <= next_offset_next;
      done        <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    kind_q          <= kind_q_next;
    size_q          <= size_q_next;
    addr_q          <= addr_q_next;
    start_q         <= start_q_next;
    status          <= status_next;
    granted_address <= granted_next;
    owned           <= owned_next;
  end

  always_comb begin
    state_next       = state;
    kind_q_next      = kind_q;
    size_q_next      = size_q;
    addr_q_next      = addr_q;
    start_q_next     = start_q;
    count_next       = count;
    next_offset_next = next_offset;
    done_next        = 1'b0;
    status_next      = status;
    granted_next     = granted_address;
    owned_next       = owned;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      ctrl[i] = '0;
    end

    unique case (state)
      S_IDLE: begin
        if (start) begin
          kind_q_next = kind;
          size_q_next = size;
          addr_q_next = address;
          // wrap to zero when the request would run past the end
          if ((acc_end > W'(lim)) || (next_offset >= lim)) begin
            start_q_next = '0;
          end else begin
            start_q_next = OFFSET_BITS'(next_offset);
          end
          if (kind == KIND_ALLOC) begin
            if (LW'(size) > lim) begin
              done_next    = 1'b1;
              status_next  = ST_TOO_LARGE;
              granted_next = '0;
              owned_next   = 1'b0;
            end else begin
              state_next = S_CLEAN;
            end
          end else if (kind == KIND_FREE || kind == KIND_OWNS) begin
            state_next = S_SEARCH;
          end else begin
            done_next    = 1'b1;
            status_next  = ST_NOT_FOUND;
            granted_next = '0;
            owned_next   = 1'b0;
          end
        end
      end
      S_CLEAN: begin
        // drop one freed head entry per cycle
        if ((count != '0) && frd[0]) begin
          for (int i = 0; i < MAX_ENTRIES; i++) begin
            ctrl[i].shift = 1'b1;
          end
          count_next = count - CW'(1);
        end else begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next   = S_IDLE;
        done_next    = 1'b1;
        granted_next = '0;
        owned_next   = 1'b0;
        if (!room) begin
          status_next = ST_WAIT;
        end else if (count == CW'(MAX_ENTRIES)) begin
          status_next = ST_FULL;
        end else begin
          status_next                 = ST_OK;
          ctrl[count[IW-1:0]].load    = 1'b1;
          count_next                  = count + CW'(1);
          next_offset_next            = LW'(chk_end);
          granted_next                = base_address + ADDR_W'(start_q);
        end
      end
      S_SEARCH: begin
        state_next   = S_IDLE;
        done_next    = 1'b1;
        granted_next = '0;
        if (kind_q == KIND_FREE) begin
          owned_next = 1'b0;
          if (hit) begin
            status_next        = ST_OK;
            ctrl[hit_idx].mark = 1'b1;
          end else begin
            status_next = ST_NOT_FOUND;
          end
        end else begin
          status_next = ST_OK;
          owned_next  = hit;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end
endmodule
`default_nettype wire

FILE: hdl/rba_cell.sv
// one entry cell of the allocation queue
`default_nettype none
module rba_cell import rba_pkg::*; #(
  parameter int OFFSET_BITS = 20
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire cell_ctrl_t             ctrl,
  input  wire logic [OFFSET_BITS-1:0] load_offset,
  input  wire logic [OFFSET_BITS-1:0] up_offset,
  input  wire logic                   up_freed,
  input  wire logic [ADDR_W-1:0]      base,
  input  wire logic [ADDR_W-1:0]      addr,
  output logic [OFFSET_BITS-1:0]      offset,
  output logic                        freed,
  output logic                        match
);
  logic [ADDR_W-1:0] entry_addr;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      offset <= load_offset;
    end else if (ctrl.shift) begin
      offset <= up_offset;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      freed <= 1'b0;
    end else if (ctrl.load) begin
      freed <= 1'b0;
    end else if (ctrl.shift) begin
      freed <= up_freed;
    end else if (ctrl.mark) begin
      freed <= 1'b1;
    end
  end

  assign entry_addr = base + ADDR_W'(offset);
  assign match      = !freed && (entry_addr == addr);
endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// self-checking testbench for the ring buffer allocator
module tb_top;
  import rba_pkg::*;

  localparam int NSLOT = 16;
  localparam int OFF_LIMIT = 1 << 20;
  localparam logic [KIND_W-1:0] KIND_BAD = 2'd3;
  localparam logic [2:0] PADDR_BUFFER_SIZE = 3'd0;
  localparam logic [2:0] PADDR_BASE_ADDRESS = 3'd4;
  localparam int SETTLE_CYCLES = 30;
  localparam int STALL_LIMIT = 4000;
  localparam int ANS_DEPTH = 16;
  localparam int DIR_DEPTH = 32;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [KIND_W-1:0] kind;
  logic [SIZE_W-1:0] size;
  logic [ADDR_W-1:0] address;
  logic done;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0] granted_address;
  logic owned;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  ring_buffer_allocator dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .kind(kind), .size(size), .address(address),
    .done(done), .status(status), .granted_address(granted_address), .owned(owned),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // one expected answer per accepted command
  typedef struct {
    logic [STATUS_W-1:0] st;
    logic [ADDR_W-1:0] grant;
    logic own;
  } answer_t;

  // expected answers in order, kept in a small ring
  answer_t answer_mem [ANS_DEPTH];
  int answer_wr = 0;
  int answer_rd = 0;
  int errors = 0;
  int stall_cycles = 0;
  int idle_pct = 0;

  // shadow of the allocator state
  logic [20:0] cfg_buf_size;
  logic [31:0] cfg_base;
  logic [20:0] slot_off [NSLOT];
  logic slot_freed [NSLOT];
  logic [3:0] head;
  int live_cnt;
  logic [20:0] next_off;

  // directed table
  typedef struct {
    logic [KIND_W-1:0] k;
    logic [SIZE_W-1:0] sz;
    logic [ADDR_W-1:0] a;
    bit typed;
    answer_t ans;
  } dir_row_t;
  dir_row_t dir_rows [DIR_DEPTH];
  int dir_n = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    errors++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // newest live unfreed entry at this address, -1 if none
  function automatic int find_owner(input logic [31:0] a);
    logic [3:0] s;
    for (int p = live_cnt - 1; p >= 0; p--) begin
      s = head + 4'(p);
      if (!slot_freed[s] && (cfg_base + 32'(slot_off[s])) == a) return int'(s);
    end
    return -1;
  endfunction

  // advance the shadow state by one command and work out its answer
  task automatic predict_answer(input logic [KIND_W-1:0] k, input logic [SIZE_W-1:0] sz,
                                input logic [ADDR_W-1:0] a, output answer_t ans);
    longint lim;
    longint first;
    logic [3:0] s;
    int hit;
    ans.st = ST_OK;
    ans.grant = '0;
    ans.own = 1'b0;
    lim = (cfg_buf_size < OFF_LIMIT) ? longint'(cfg_buf_size) : longint'(OFF_LIMIT);
    case (k)
      KIND_ALLOC: begin
        if (longint'(sz) > lim) begin
          ans.st = ST_TOO_LARGE;
        end else begin
          first = longint'(next_off);
          if (first + sz > lim || first >= lim) first = 0;
          // drop freed entries at the head
          while (live_cnt > 0 && slot_freed[head]) begin
            slot_freed[head] = 1'b0;
            head = head + 4'd1;
            live_cnt--;
          end
          if (live_cnt > 0 && longint'(slot_off[head]) >= first &&
              longint'(slot_off[head]) < first + sz) begin
            ans.st = ST_WAIT;
          end else if (live_cnt >= NSLOT) begin
            ans.st = ST_FULL;
          end else begin
            s = head + 4'(live_cnt);
            slot_off[s] = 21'(first);
            slot_freed[s] = 1'b0;
            live_cnt++;
            next_off = 21'(first + sz);
            ans.grant = cfg_base + 32'(first);
          end
        end
      end
      KIND_FREE: begin
        hit = find_owner(a);
        if (hit < 0) ans.st = ST_NOT_FOUND;
        else slot_freed[hit] = 1'b1;
      end
      KIND_OWNS: ans.own = (find_owner(a) >= 0);
      default: ans.st = ST_NOT_FOUND;
    endcase
  endtask

  // drive one command and hold it until accepted; start stays high afterwards
  task automatic issue(input logic [KIND_W-1:0] k, input logic [SIZE_W-1:0] sz,
                       input logic [ADDR_W-1:0] a, input bit typed, input answer_t typed_ans);
    answer_t ans;
    @(negedge clk);
    start = 1'b1;
    kind = k;
    size = sz;
    address = a;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    predict_answer(k, sz, a, ans);
    answer_mem[answer_wr % ANS_DEPTH] = typed ? typed_ans : ans;
    answer_wr++;
  endtask

  task automatic go_quiet(input int n);
    @(negedge clk);
    start = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // stop sending and wait for every answer, then pause with start low
  task automatic drain();
    go_quiet(1);
    while (answer_wr != answer_rd) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] where, input logic [31:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = where;
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    if (where == PADDR_BUFFER_SIZE) cfg_buf_size = value[20:0];
    else cfg_base = value;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic add_row(input logic [KIND_W-1:0] k, input logic [SIZE_W-1:0] sz,
                         input logic [ADDR_W-1:0] a, input bit typed,
                         input logic [STATUS_W-1:0] st, input logic [ADDR_W-1:0] g,
                         input logic o);
    dir_row_t r;
    r.k = k;
    r.sz = sz;
    r.a = a;
    r.typed = typed;
    r.ans.st = st;
    r.ans.grant = g;
    r.ans.own = o;
    dir_rows[dir_n] = r;
    dir_n++;
  endtask

  // address of a random queued entry, freed or not
  function automatic logic [31:0] queued_addr();
    logic [3:0] s;
    s = head + 4'($urandom_range(live_cnt - 1));
    return cfg_base + 32'(slot_off[s]);
  endfunction

  // mostly allocations that fit, frees and queries of real entries, some noise
  task automatic random_cmd();
    answer_t none;
    longint lim;
    int r;
    logic [KIND_W-1:0] k;
    logic [SIZE_W-1:0] sz;
    logic [ADDR_W-1:0] a;
    none = '{default: '0};
    lim = (cfg_buf_size < OFF_LIMIT) ? longint'(cfg_buf_size) : longint'(OFF_LIMIT);
    r = $urandom_range(99);
    sz = 21'($urandom_range(0, int'(lim / 5)));
    a = $urandom;
    if (r < 50) begin
      k = KIND_ALLOC;
      case ($urandom_range(19))
        0: sz = 21'(lim);
        1: sz = 21'(lim + 1);
        2: sz = 21'($urandom);
        3: sz = '0;
        default: ;
      endcase
    end else if (r < 92) begin
      k = (r < 76) ? KIND_FREE : KIND_OWNS;
      if (live_cnt > 0 && $urandom_range(99) < 85) a = queued_addr();
    end else begin
      k = KIND_BAD;
      sz = 21'($urandom);
    end
    issue(k, sz, a, 1'b0, none);
    if ($urandom_range(99) < idle_pct) go_quiet($urandom_range(1, 8));
  endtask

  // result side: compare each beat against the oldest expectation
  always @(posedge clk) begin
    answer_t e;
    if (!rst && done) begin
      if (answer_wr == answer_rd) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        e = answer_mem[answer_rd % ANS_DEPTH];
        answer_rd++;
        if (status !== e.st)
          report_mismatch($sformatf("status %0d, expected %0d", status, e.st));
        if (granted_address !== e.grant)
          report_mismatch($sformatf("granted_address %h, expected %h",
                                    granted_address, e.grant));
        if (owned !== e.own)
          report_mismatch($sformatf("owned %0b, expected %0b", owned, e.own));
      end
    end
  end

  // watchdog: give up after a long stretch with no beat on either side
  always @(posedge clk) begin
    if (rst || done || (start && !busy) || psel) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    answer_t none;
    int pcts [4];
    logic [20:0] sizes [6];
    none = '{default: '0};
    pcts = '{0, 48, 0, 23};
    sizes = '{21'd1048576, 21'd1, 21'd64, 21'd256, 21'h1FFFFF, 21'd100};
    rst = 1'b1;
    start = 1'b0;
    kind = KIND_ALLOC;
    size = '0;
    address = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cfg_buf_size = 21'd1048576;
    cfg_base = '0;
    for (int i = 0; i < NSLOT; i++) begin
      slot_off[i] = '0;
      slot_freed[i] = 1'b0;
    end
    head = '0;
    live_cnt = 0;
    next_off = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part at reset settings: buffer of 2^20 bytes at address zero
    add_row(KIND_ALLOC, 21'd1048577, '0, 1, ST_TOO_LARGE, '0, 0);
    add_row(KIND_ALLOC, 21'h1FFFFF, '0, 1, ST_TOO_LARGE, '0, 0);
    add_row(KIND_BAD, 21'd5, 32'h10, 1, ST_NOT_FOUND, '0, 0);
    add_row(KIND_FREE, '0, 32'd12345, 1, ST_NOT_FOUND, '0, 0);
    add_row(KIND_OWNS, '0, 32'hFFFFFFFF, 1, ST_OK, '0, 0);
    add_row(KIND_ALLOC, 21'd1048576, '0, 1, ST_OK, '0, 0);
    add_row(KIND_ALLOC, '0, '0, 0, ST_OK, '0, 0);    // zero size right at the end
    add_row(KIND_OWNS, '0, '0, 0, ST_OK, '0, 0);
    add_row(KIND_ALLOC, 21'd16, '0, 0, ST_OK, '0, 0); // head is in the way
    add_row(KIND_FREE, '0, '0, 0, ST_OK, '0, 0);      // newest match goes first
    add_row(KIND_FREE, '0, '0, 0, ST_OK, '0, 0);
    add_row(KIND_FREE, '0, '0, 1, ST_NOT_FOUND, '0, 0);
    add_row(KIND_OWNS, '0, '0, 1, ST_OK, '0, 0);
    add_row(KIND_ALLOC, 21'd100, '0, 0, ST_OK, '0, 0); // cleanup of two freed
    add_row(KIND_ALLOC, 21'd1000, '0, 0, ST_OK, '0, 0);
    add_row(KIND_OWNS, '0, 32'd100, 0, ST_OK, '0, 0);
    add_row(KIND_ALLOC, 21'd1048576, '0, 0, ST_OK, '0, 0);
    for (int i = 0; i < dir_n; i++) issue(dir_rows[i].k, dir_rows[i].sz, dir_rows[i].a,
                                          dir_rows[i].typed, dir_rows[i].ans);
    drain();

    // random part, one phase per register setting; extremes included
    for (int ph = 0; ph < 6; ph++) begin
      reg_write(PADDR_BUFFER_SIZE, 32'(sizes[ph]));
      reg_write(PADDR_BASE_ADDRESS, (ph == 1) ? 32'hFFFFFFFF :
                                    (ph == 3) ? 32'h80000000 :
                                    (ph == 4) ? 32'h0 : $urandom);
      idle_pct = pcts[ph % 4];
      for (int n = 0; n < 147; n++) begin
        random_cmd();
        if (n == 70) drain();  // sender holds off until all answers are in
      end
      drain();
    end

    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end
endmodule
